FILE: design/adcss_pkg.sv
// Shared types, constants and helpers for the ADC scan sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package adcss_pkg;

  // Defaults for top-level parameters
  localparam int MaxChannelsDef = 12;
  localparam int AddrBitsDef    = 16;
  localparam int ResultBitsDef  = 10;

  // Fixed field widths
  localparam int ChanBits       = 4;
  localparam int NumListEntries = 12;
  localparam int ListBits       = NumListEntries * ChanBits;
  localparam int CountBits      = 8;
  localparam int AddrPortBits   = 16;
  localparam int DataPortBits   = 10;
  localparam int MuxBits        = 8;
  localparam int RefBits        = 2;
  localparam int ReqBits        = 2;
  localparam int CfgIdxBits     = 2;
  localparam int CfgDataBits    = ListBits;

  localparam logic [MuxBits-1:0] MuxHighBase = 8'h80;

  typedef enum logic [ReqBits-1:0] {
    ReqStart  = 2'd0,
    ReqDone   = 2'd1,
    ReqStatus = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgChannelCount = 2'd0,
    CfgChannelList  = 2'd1,
    CfgRefSelect    = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [ChanBits-1:0] channel_count;
    logic [ListBits-1:0] channel_list;
    logic [RefBits-1:0]  reference_select;
  } cfg_t;

  typedef struct packed {
    logic                    start_accepted;
    logic                    write_enable;
    logic [AddrPortBits-1:0] write_address;
    logic [DataPortBits-1:0] write_data;
    logic                    start_convert;
    logic [MuxBits-1:0]      mux_code;
    logic [RefBits-1:0]      reference_out;
    logic                    finished;
    logic                    idle;
  } result_t;

  // Physical channel of a scan-list slot mapped to the mux code.
  // Slots past the list read as channel 0.
  function automatic logic [MuxBits-1:0] mux_code_for(logic [ListBits-1:0] list,
                                                      logic [ChanBits-1:0] idx);
    logic [ChanBits-1:0] ch;
    ch = '0;
    if (idx < ChanBits'(NumListEntries)) begin
      ch = list[idx*ChanBits +: ChanBits];
    end
    if (ch[ChanBits-1]) begin
      return MuxHighBase | {{(MuxBits-ChanBits+1){1'b0}}, ch[ChanBits-2:0]};
    end
    return {{(MuxBits-ChanBits){1'b0}}, ch};
  endfunction

endpackage

`default_nettype wire

FILE: design/adcss_cfg_regs.sv
// Configuration registers of the ADC scan sequencer.
// Depends on adcss_pkg.
`default_nettype none

module adcss_cfg_regs
  import adcss_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgChannelCount: cfg_d.channel_count    = cfg_data_i[ChanBits-1:0];
        CfgChannelList:  cfg_d.channel_list     = cfg_data_i[ListBits-1:0];
        CfgRefSelect:    cfg_d.reference_select = cfg_data_i[RefBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count    <= ChanBits'(1);
      cfg_q.channel_list     <= '0;
      cfg_q.reference_select <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/adcss_seq.sv
// Input register, scan state and single-pass result logic of the sequencer.
// Depends on adcss_pkg.
`default_nettype none

module adcss_seq
  import adcss_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDef,
  parameter int ADDRESS_BITS = AddrBitsDef,
  parameter int RESULT_BITS  = ResultBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [ReqBits-1:0]      req_type_i,
  input  wire logic [CountBits-1:0]    sample_count_i,
  input  wire logic [AddrPortBits-1:0] base_address_i,
  input  wire logic [DataPortBits-1:0] conversion_result_i,
  input  wire logic                    res_ready_i,
  output logic                         res_valid_o,
  output result_t                      res_o
);

  localparam int DataBits = (RESULT_BITS < DataPortBits) ? RESULT_BITS : DataPortBits;
  localparam logic [DataPortBits-1:0] DataMask =
    DataPortBits'((64'd1 << DataBits) - 64'd1);
  localparam logic [ChanBits:0] MaxCnt = (ChanBits + 1)'(MAX_CHANNELS);

  // Input register
  logic                    in_valid_q;
  logic [ReqBits-1:0]      req_q;
  logic [CountBits-1:0]    cnt_q;
  logic [AddrPortBits-1:0] base_q;
  logic [DataPortBits-1:0] data_q;

  logic take, load;
  assign take       = in_valid_q & res_ready_i;
  assign in_stall_o = in_valid_q & ~res_ready_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q  <= req_type_i;
      cnt_q  <= sample_count_i;
      base_q <= base_address_i;
      data_q <= conversion_result_i;
    end
  end

  // Scan state
  logic                    busy_q, busy_d;
  logic [ChanBits-1:0]     idx_q, idx_d;
  logic [CountBits-1:0]    rounds_q, rounds_d;
  logic [ADDRESS_BITS-1:0] ptr_q, ptr_d;

  logic [ChanBits:0]   active_cnt;
  logic [ChanBits-1:0] idx_next;
  result_t             res;

  always_comb begin
    active_cnt = {1'b0, cfg_i.channel_count};
    if (active_cnt == '0) begin
      active_cnt = (ChanBits + 1)'(1);
    end else if (active_cnt > MaxCnt) begin
      active_cnt = MaxCnt;
    end
  end

  assign idx_next = idx_q + ChanBits'(1);

  always_comb begin
    busy_d   = busy_q;
    idx_d    = idx_q;
    rounds_d = rounds_q;
    ptr_d    = ptr_q;
    res      = '0;
    unique case (req_type_e'(req_q))
      ReqStart: begin
        if (!busy_q) begin
          busy_d             = 1'b1;
          idx_d              = '0;
          rounds_d           = (cnt_q == '0) ? CountBits'(1) : cnt_q;
          ptr_d              = ADDRESS_BITS'(base_q);
          res.start_accepted = 1'b1;
          res.start_convert  = 1'b1;
          res.mux_code       = mux_code_for(cfg_i.channel_list, '0);
          res.reference_out  = cfg_i.reference_select;
        end
      end
      ReqDone: begin
        if (busy_q) begin
          res.write_enable  = 1'b1;
          res.write_address = AddrPortBits'(ptr_q);
          res.write_data    = data_q & DataMask;
          idx_d             = idx_next;
          if ({1'b0, idx_next} < active_cnt) begin
            ptr_d             = ptr_q + ADDRESS_BITS'(1);
            res.start_convert = 1'b1;
            res.mux_code      = mux_code_for(cfg_i.channel_list, idx_next);
            res.reference_out = cfg_i.reference_select;
          end else if (rounds_q > CountBits'(1)) begin
            // wrap to the first channel for the next round
            ptr_d             = ptr_q + ADDRESS_BITS'(1);
            rounds_d          = rounds_q - CountBits'(1);
            idx_d             = '0;
            res.start_convert = 1'b1;
            res.mux_code      = mux_code_for(cfg_i.channel_list, '0);
            res.reference_out = cfg_i.reference_select;
          end else begin
            busy_d       = 1'b0;
            res.finished = 1'b1;
          end
        end
      end
      default: ;  // status query and unused code
    endcase
    res.idle = ~busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      rounds_q <= '0;
      ptr_q    <= '0;
    end else if (take) begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      rounds_q <= rounds_d;
      ptr_q    <= ptr_d;
    end
  end

  assign res_valid_o = in_valid_q;
  assign res_o       = res;

endmodule

`default_nettype wire

FILE: design/adcss_out_reg.sv
// Result register on the output channel of the sequencer.
// Depends on adcss_pkg.
`default_nettype none

module adcss_out_reg
  import adcss_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_valid_i,
  output logic         res_ready_o,
  input  wire result_t res_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_o
);

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

FILE: design/adc_multichannel_scan_sequencer_core.sv
// ADC multichannel scan sequencer, top level.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output does not stall; the scan state
// updates as an item moves into the result register, so consecutive items see
// each other's effect with no bubble.
// Reset: asynchronous, active low; block idle, scan state zero, channel_count 1.
`default_nettype none

module adc_multichannel_scan_sequencer_core
  import adcss_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDef,
  parameter int ADDRESS_BITS = AddrBitsDef,
  parameter int RESULT_BITS  = ResultBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i,
  // input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [ReqBits-1:0]      req_type_i,
  input  wire logic [CountBits-1:0]    sample_count_i,
  input  wire logic [AddrPortBits-1:0] base_address_i,
  input  wire logic [DataPortBits-1:0] conversion_result_i,
  // output channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         start_accepted_o,
  output logic                         write_enable_o,
  output logic [AddrPortBits-1:0]      write_address_o,
  output logic [DataPortBits-1:0]      write_data_o,
  output logic                         start_convert_o,
  output logic [MuxBits-1:0]           mux_code_o,
  output logic [RefBits-1:0]           reference_out_o,
  output logic                         finished_o,
  output logic                         idle_o
);

  cfg_t    cfg;
  result_t res, out;
  logic    res_valid, res_ready;

  adcss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  adcss_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .ADDRESS_BITS (ADDRESS_BITS),
    .RESULT_BITS  (RESULT_BITS)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .sample_count_i      (sample_count_i),
    .base_address_i      (base_address_i),
    .conversion_result_i (conversion_result_i),
    .res_ready_i         (res_ready),
    .res_valid_o         (res_valid),
    .res_o               (res)
  );

  adcss_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign start_accepted_o = out.start_accepted;
  assign write_enable_o   = out.write_enable;
  assign write_address_o  = out.write_address;
  assign write_data_o     = out.write_data;
  assign start_convert_o  = out.start_convert;
  assign mux_code_o       = out.mux_code;
  assign reference_out_o  = out.reference_out;
  assign finished_o       = out.finished;
  assign idle_o           = out.idle;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for adc_multichannel_scan_sequencer_core: directed and random scan traffic,
// each result checked against an untimed model of the sequencer kept in this file.
// Depends on adcss_pkg and the design sources.

module tb_top;
  import adcss_pkg::*;

  localparam int ClkHalf    = 5;
  localparam int ResetLen   = 7;
  localparam int HoldCycles = 40;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 120;
  localparam int NumPhases  = 8;
  localparam int MaxPrinted = 40;
  localparam logic [ReqBits-1:0] ReqUnused = 2'd3;  // undefined code, acts as a status query

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0]   cfg_index  = '0;
  logic [CfgDataBits-1:0]  cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [ReqBits-1:0]      req_type   = ReqStatus;
  logic [CountBits-1:0]    samp_count = '0;
  logic [AddrPortBits-1:0] base_addr  = '0;
  logic [DataPortBits-1:0] conv_value = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic                    start_accepted, write_enable, start_convert, finished, idle;
  logic [AddrPortBits-1:0] write_address;
  logic [DataPortBits-1:0] write_data;
  logic [MuxBits-1:0]      mux_code;
  logic [RefBits-1:0]      reference_out;

  // scan model state and its copy of the registers
  logic [ChanBits-1:0]     m_count = 4'd1;
  logic [ListBits-1:0]     m_list  = '0;
  logic [RefBits-1:0]      m_ref   = '0;
  logic                    scan_busy   = 1'b0;
  logic [ChanBits-1:0]     slot        = '0;
  logic [CountBits-1:0]    rounds_left = '0;
  logic [AddrPortBits-1:0] wr_ptr      = '0;

  result_t expected_results[$];

  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;
  int fail_count   = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int useful_items = 0;
  int scans_taken  = 0;
  int stores_seen  = 0;
  int scans_ended  = 0;
  int cfg_writes   = 0;

  always #ClkHalf clk_i = ~clk_i;

  adc_multichannel_scan_sequencer_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .sample_count_i     (samp_count),
    .base_address_i     (base_addr),
    .conversion_result_i(conv_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .start_accepted_o   (start_accepted),
    .write_enable_o     (write_enable),
    .write_address_o    (write_address),
    .write_data_o       (write_data),
    .start_convert_o    (start_convert),
    .mux_code_o         (mux_code),
    .reference_out_o    (reference_out),
    .finished_o         (finished),
    .idle_o             (idle)
  );

  // ---------------------------------------------------------------- model

  function automatic logic [ChanBits-1:0] active_channels();
    if (m_count == '0) return 4'd1;
    if (m_count > ChanBits'(MaxChannelsDef)) return ChanBits'(MaxChannelsDef);
    return m_count;
  endfunction

  function automatic logic [MuxBits-1:0] mux_of_slot(input logic [ChanBits-1:0] s);
    logic [ChanBits-1:0] ch;
    ch = (s < ChanBits'(NumListEntries)) ? m_list[s*ChanBits +: ChanBits] : '0;
    if (ch >= 4'd8) return MuxHighBase + MuxBits'(ch - 4'd8);
    return MuxBits'(ch);
  endfunction

  // Advances the scan model by one item and returns the result it should produce.
  function automatic result_t scan_step(input logic [ReqBits-1:0] req,
                                        input logic [CountBits-1:0] cnt,
                                        input logic [AddrPortBits-1:0] base,
                                        input logic [DataPortBits-1:0] value);
    result_t r;
    r = '0;
    if (req == ReqStart) begin
      if (!scan_busy) begin
        scan_busy        = 1'b1;
        slot             = '0;
        rounds_left      = (cnt == '0) ? 8'd1 : cnt;
        wr_ptr           = base;
        r.start_accepted = 1'b1;
        r.start_convert  = 1'b1;
        r.mux_code       = mux_of_slot('0);
        r.reference_out  = m_ref;
      end
    end else if (req == ReqDone) begin
      if (scan_busy) begin
        r.write_enable  = 1'b1;
        r.write_address = wr_ptr;
        r.write_data    = value;
        slot            = slot + 4'd1;
        if (slot < active_channels()) begin
          wr_ptr          = wr_ptr + 16'd1;
          r.start_convert = 1'b1;
          r.mux_code      = mux_of_slot(slot);
          r.reference_out = m_ref;
        end else if (rounds_left > 8'd1) begin
          wr_ptr          = wr_ptr + 16'd1;
          rounds_left     = rounds_left - 8'd1;
          slot            = '0;
          r.start_convert = 1'b1;
          r.mux_code      = mux_of_slot('0);
          r.reference_out = m_ref;
        end else begin
          scan_busy  = 1'b0;
          r.finished = 1'b1;
        end
      end
    end
    r.idle = !scan_busy;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  // Offers one item, waits until it is taken, records the expected result.
  task automatic send_item(input logic [ReqBits-1:0] req, input logic [CountBits-1:0] cnt,
                           input logic [AddrPortBits-1:0] base,
                           input logic [DataPortBits-1:0] value);
    result_t r;
    in_valid   <= 1'b1;
    req_type   <= req;
    samp_count <= cnt;
    base_addr  <= base;
    conv_value <= value;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    r = scan_step(req, cnt, base, value);
    expected_results.push_back(r);
    items_sent++;
    if (r.start_accepted || r.write_enable) useful_items++;
    scans_taken += r.start_accepted;
    stores_seen += r.write_enable;
    scans_ended += r.finished;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stops offering items and waits until every result is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [CfgDataBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgChannelCount: m_count = data[ChanBits-1:0];
      CfgChannelList:  m_list  = data[ListBits-1:0];
      CfgRefSelect:    m_ref   = data[RefBits-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input logic [ChanBits-1:0] cnt, input logic [ListBits-1:0] list,
                            input logic [RefBits-1:0] refsel);
    cfg_write(CfgChannelCount, CfgDataBits'(cnt));
    cfg_write(CfgChannelList, list);
    cfg_write(CfgRefSelect, CfgDataBits'(refsel));
  endtask

  // Mostly complete scans with random content; the rest are ignored or stray items.
  task automatic run_scans(input int target);
    int first;
    int pick;
    logic [ReqBits-1:0] req;
    logic [CountBits-1:0] cnt;
    first = useful_items;
    while (useful_items - first < target) begin
      pick = $urandom_range(0, 99);
      cnt  = CountBits'($urandom);
      if (!scan_busy) begin
        if (pick < 88) begin
          req = ReqStart;
          // long scans only where the list is short
          if (!($urandom_range(0, 29) == 0 && active_channels() <= 2))
            cnt = CountBits'($urandom_range(0, 4));
        end else if (pick < 96) req = ReqDone;
        else if (pick < 98) req = ReqStatus;
        else req = ReqUnused;
      end else begin
        if (pick < 86) req = ReqDone;
        else if (pick < 92) req = ReqStart;
        else if (pick < 96) req = ReqStatus;
        else req = ReqUnused;
      end
      send_item(req, cnt, AddrPortBits'($urandom), DataPortBits'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= MaxPrinted)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending", 16'd0, 16'd0);
      end else begin
        want = expected_results.pop_front();
        check_field("start_accepted", 16'(start_accepted), 16'(want.start_accepted));
        check_field("write_enable", 16'(write_enable), 16'(want.write_enable));
        check_field("write_address", write_address, want.write_address);
        check_field("write_data", 16'(write_data), 16'(want.write_data));
        check_field("start_convert", 16'(start_convert), 16'(want.start_convert));
        check_field("mux_code", 16'(mux_code), 16'(want.mux_code));
        check_field("reference_out", 16'(reference_out), 16'(want.reference_out));
        check_field("finished", 16'(finished), 16'(want.finished));
        check_field("idle", 16'(idle), 16'(want.idle));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset defaults: queries, stray done, zero round count on a one-entry list.
  task automatic test_idle_requests();
    send_item(ReqStatus, 8'h00, 16'h0000, 10'h000);
    send_item(ReqUnused, 8'hFF, 16'hFFFF, 10'h3FF);
    send_item(ReqDone, 8'h00, 16'h0000, 10'h155);
    send_item(ReqStart, 8'h00, 16'h0000, 10'h000);
    send_item(ReqDone, 8'hFF, 16'hFFFF, 10'h3FF);
  endtask

  // Saturated count, all mux ranges, address wrap, start while busy.
  task automatic test_full_list_wrap();
    settle();
    set_config(4'd15, 48'h319A_BCDE_F870, 2'd3);
    send_item(ReqStart, 8'h01, 16'hFFFA, 10'h000);
    send_item(ReqStart, 8'hFF, 16'hFFFF, 10'h3FF);
    for (int i = 0; i < MaxChannelsDef; i++)
      send_item(ReqDone, 8'h00, 16'h0000, (i % 2) ? 10'h3FF : 10'h000);
  endtask

  // Channel count dropped mid-scan: the next done wraps or ends the round early.
  task automatic test_live_count_change();
    settle();
    set_config(4'd2, 48'h0000_0000_00F8, 2'd1);
    send_item(ReqStart, 8'h02, 16'h1234, 10'h000);
    send_item(ReqDone, 8'h00, 16'h0000, 10'h2AA);
    settle();
    cfg_write(CfgChannelCount, '0);
    send_item(ReqDone, 8'h00, 16'h0000, 10'h0F0);
    send_item(ReqDone, 8'h00, 16'h0000, 10'h30F);
  endtask

  // Largest round count; the scan runs on into the random traffic.
  task automatic test_long_scan_start();
    settle();
    set_config(4'd1, 48'hFFFF_FFFF_FFFF, 2'd2);
    send_item(ReqStart, 8'hFF, 16'hFF00, 10'h000);
  endtask

  // Receiver holds off while items keep coming, so the input side backs up.
  task automatic test_receiver_hold();
    settle();
    idling_on    = 1'b0;
    hold_request = 1'b1;
    run_scans(30);
    settle();
  endtask

  // Random scans over a series of register settings; each phase starts from a drained block.
  task automatic test_random_phases();
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: set_config(4'd1, 48'hFFFF_FFFF_FFFF, 2'd2);
        1: set_config(4'd12, ListBits'({$urandom, $urandom}), 2'd3);
        2: set_config(4'd0, 48'h0, 2'd0);
        default: set_config(ChanBits'($urandom_range(0, 15)), ListBits'({$urandom, $urandom}),
                            RefBits'($urandom_range(0, 3)));
      endcase
      idling_on = !(p == 3 || p >= NumPhases - 2);
      run_scans(PhaseItems);
    end
  endtask

  initial begin
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_full_list_wrap();
    test_live_count_change();
    test_long_scan_start();
    test_receiver_hold();
    test_random_phases();
    settle();
    $display("Run covered %0d items: %0d scans started, %0d results stored, %0d scans done.",
             items_sent, scans_taken, stores_seen, scans_ended);
    $display("Register writes: %0d; mismatches: %0d.", cfg_writes, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/adcss_pkg.sv
design/adcss_cfg_regs.sv
design/adcss_seq.sv
design/adcss_out_reg.sv
design/adc_multichannel_scan_sequencer_core.sv
dv/tb_top.sv
